@@ hdl/keyframe_track_interpolator_assert.svh @@
// Assertion macros used by the checker file.
`ifndef KEYFRAME_TRACK_INTERPOLATOR_ASSERT_SVH
`define KEYFRAME_TRACK_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define KTI_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kti: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define KTI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kti: next-cycle check failed");

`endif

@@ hdl/kti_pkg.sv @@
`default_nettype none

package kti_pkg;

    localparam int MAX_KEYS_DEF = 64;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_FRAMES = 1'b1;

    localparam int KEY_COUNT_W = 7;
    localparam int FRAME_W     = 16;
    localparam int VALUE_W     = 32;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // Shared divider: 48-bit dividend, 16-bit divisor, two quotient bits a cycle
    localparam int DIV_W           = 48;
    localparam int DEN_W           = 16;
    localparam int STEPS_PER_CYCLE = 2;
    localparam int DIV_CYCLES      = DIV_W / STEPS_PER_CYCLE;
    localparam int MOD_BITS        = 18;
    localparam int MOD_CYCLES      = MOD_BITS / STEPS_PER_CYCLE;
    localparam int CNT_W           = $clog2(DIV_CYCLES + 1);

    typedef struct packed {
        logic                      opcode;
        logic [5:0]                key_index;
        logic [FRAME_W-1:0]        key_frame;
        logic signed [VALUE_W-1:0] key_value;
        logic signed [15:0]        play_frame;
        logic signed [15:0]        frame_shift;
    } t_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] track_value;
        logic [FRAME_W-1:0]        wrapped_frame;
        logic                      matched;
    } t_result;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] cycles;
        logic [DIV_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } t_div_cmd;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DEN_W-1:0] remainder;
    } t_div_rsp;

endpackage

`default_nettype wire

@@ hdl/kti_div.sv @@
`default_nettype none

module kti_div
    import kti_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_cmd i_cmd,
    output t_div_rsp      o_rsp
);

    logic [DIV_W-1:0] r_quo, n_quo;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_run;
    logic             r_done;

    // Restoring division, two quotient bits per cycle
    always_comb begin
        logic [DEN_W:0] trial;
        logic           ge;
        n_quo = r_quo;
        n_rem = r_rem;
        for (int k = 0; k < STEPS_PER_CYCLE; k++) begin
            trial = {n_rem, n_quo[DIV_W-1]};
            ge    = (trial >= {1'b0, r_den});
            n_rem = ge ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
            n_quo = {n_quo[DIV_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_run <= 1'b1;
                r_cnt <= i_cmd.cycles;
            end else if (r_run) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_quo <= i_cmd.dividend;
            r_rem <= '0;
            r_den <= i_cmd.divisor;
        end else if (r_run) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

`default_nettype wire

@@ hdl/keyframe_track_interpolator.sv @@
// Write item: the result strobe follows on the next cycle and busy stays low.
// Evaluate item: busy while the wrap remainder is computed on the shared divider, then while
// the keys in use are scanned with one keyframe read a cycle, and then while the quotient for a
// segment with distinct frames is computed on the shared divider; fewer than two keys skip the scan.
// Synchronous active-low reset clears the sequencer, key_count (0) and loop_frames (2);
// the keyframe table is not cleared. Results cannot be stalled by the receiver.
`default_nettype none

module keyframe_track_interpolator
    import kti_pkg::*;
#(
    parameter int MAX_KEYS = MAX_KEYS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire t_item                 i_item,
    output logic                       o_busy,
    output logic                       o_done,
    output t_result                    o_result,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW  = $clog2(MAX_KEYS);
    localparam int NW0 = $clog2(MAX_KEYS + 1);
    localparam int NW  = (NW0 > KEY_COUNT_W) ? NW0 : KEY_COUNT_W;
    localparam int MW  = FRAME_W + VALUE_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WRAP = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;

    logic [2:0]               r_state, n_state;
    logic                     r_done, n_done;
    t_result                  r_result, n_result;
    logic [KEY_COUNT_W-1:0]   r_key_count;
    logic [FRAME_W-1:0]       r_loop_frames;

    logic                     r_xneg, n_xneg;
    logic [FRAME_W-1:0]       r_period, n_period;
    logic [FRAME_W-1:0]       r_wrap, n_wrap;
    logic [AW-1:0]            r_idx, n_idx;
    logic [FRAME_W-1:0]       r_prev_frame, n_prev_frame;
    logic signed [VALUE_W-1:0] r_prev_value, n_prev_value;
    logic signed [VALUE_W-1:0] r_v0, n_v0;
    logic signed [VALUE_W:0]  r_diff, n_diff;
    logic [FRAME_W-1:0]       r_dw, n_dw;
    logic [FRAME_W-1:0]       r_den, n_den;
    logic                     r_neg, n_neg;

    logic [MW-1:0]            mem [MAX_KEYS];
    logic [MW-1:0]            r_rdata;
    logic [AW-1:0]            rd_addr;
    logic                     mem_we;
    logic [FRAME_W-1:0]       rd_frame;
    logic signed [VALUE_W-1:0] rd_value;

    t_div_cmd                 div_cmd;
    t_div_rsp                 div_rsp;

    logic signed [16:0]       frame_sum;
    logic signed [17:0]       frame_m1;
    logic [17:0]              frame_mag;
    logic [FRAME_W-1:0]       period;
    logic [NW-1:0]            n_keys;
    logic [FRAME_W-1:0]       mod_fix;
    logic [VALUE_W:0]         diff_mag;
    logic [48:0]              prod;
    logic [VALUE_W:0]         quo_signed;

    assign rd_frame = r_rdata[MW-1:VALUE_W];
    assign rd_value = r_rdata[VALUE_W-1:0];

    assign frame_sum = {i_item.play_frame[15], i_item.play_frame}
                     + {i_item.frame_shift[15], i_item.frame_shift};
    assign frame_m1  = {frame_sum[16], frame_sum} - 18'sd1;
    assign frame_mag = frame_m1[17] ? 18'(-frame_m1) : 18'(frame_m1);
    assign period    = (r_loop_frames < FRAME_W'(2)) ? FRAME_W'(1)
                                                     : r_loop_frames - FRAME_W'(1);
    assign n_keys    = (NW'(r_key_count) > NW'(MAX_KEYS)) ? NW'(MAX_KEYS)
                                                          : NW'(r_key_count);

    // Truncating remainder carries the sign of the dividend; fold it back into range
    assign mod_fix    = (r_xneg && (div_rsp.remainder != '0))
                      ? r_period - div_rsp.remainder : div_rsp.remainder;
    assign diff_mag   = r_diff[VALUE_W] ? (VALUE_W+1)'(-r_diff) : (VALUE_W+1)'(r_diff);
    assign prod       = 49'(diff_mag) * 49'(r_dw);
    assign quo_signed = r_neg ? (VALUE_W+1)'(-div_rsp.quotient[VALUE_W:0])
                              : div_rsp.quotient[VALUE_W:0];

    always_comb begin
        n_state      = r_state;
        n_done       = 1'b0;
        n_result     = r_result;
        n_xneg       = r_xneg;
        n_period     = r_period;
        n_wrap       = r_wrap;
        n_idx        = r_idx;
        n_prev_frame = r_prev_frame;
        n_prev_value = r_prev_value;
        n_v0         = r_v0;
        n_diff       = r_diff;
        n_dw         = r_dw;
        n_den        = r_den;
        n_neg        = r_neg;
        mem_we       = 1'b0;
        rd_addr      = r_idx + AW'(1);
        div_cmd      = '0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_item.opcode == OP_WRITE) begin
                        mem_we   = (int'(i_item.key_index) < MAX_KEYS);
                        n_done   = 1'b1;
                        n_result = '0;
                    end else begin
                        n_xneg           = frame_m1[17];
                        n_period         = period;
                        div_cmd.start    = 1'b1;
                        div_cmd.cycles   = CNT_W'(MOD_CYCLES);
                        div_cmd.dividend = {frame_mag, (DIV_W-MOD_BITS)'(0)};
                        div_cmd.divisor  = period;
                        n_state          = S_WRAP;
                    end
                end
            end
            S_WRAP: begin
                if (div_rsp.done) begin
                    n_wrap = mod_fix + FRAME_W'(1);
                    if (n_keys < NW'(2)) begin
                        n_done   = 1'b1;
                        n_result = '{track_value: '0, wrapped_frame: mod_fix + FRAME_W'(1),
                                     matched: 1'b0};
                        n_state  = S_IDLE;
                    end else begin
                        rd_addr = '0;
                        n_idx   = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_idx == '0) begin
                    n_prev_frame = rd_frame;
                    n_prev_value = rd_value;
                    n_idx        = AW'(1);
                end else if ((r_wrap >= r_prev_frame) && (r_wrap <= rd_frame)) begin
                    if (r_prev_frame == rd_frame) begin
                        n_done   = 1'b1;
                        n_result = '{track_value: r_prev_value, wrapped_frame: r_wrap,
                                     matched: 1'b1};
                        n_state  = S_IDLE;
                    end else begin
                        n_v0    = r_prev_value;
                        n_diff  = {rd_value[VALUE_W-1], rd_value}
                                - {r_prev_value[VALUE_W-1], r_prev_value};
                        n_dw    = r_wrap - r_prev_frame;
                        n_den   = rd_frame - r_prev_frame;
                        n_state = S_MUL;
                    end
                end else if (NW'(r_idx) + NW'(1) == n_keys) begin
                    n_done   = 1'b1;
                    n_result = '{track_value: '0, wrapped_frame: r_wrap, matched: 1'b0};
                    n_state  = S_IDLE;
                end else begin
                    n_prev_frame = rd_frame;
                    n_prev_value = rd_value;
                    n_idx        = r_idx + AW'(1);
                end
            end
            S_MUL: begin
                n_neg            = r_diff[VALUE_W];
                div_cmd.start    = 1'b1;
                div_cmd.cycles   = CNT_W'(DIV_CYCLES);
                div_cmd.dividend = prod[DIV_W-1:0];
                div_cmd.divisor  = r_den;
                n_state          = S_DIV;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_done   = 1'b1;
                    n_result = '{track_value: VALUE_W'({r_v0[VALUE_W-1], r_v0} + quo_signed),
                                 wrapped_frame: r_wrap, matched: 1'b1};
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_done        <= 1'b0;
            r_key_count   <= '0;
            r_loop_frames <= FRAME_W'(2);
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_KEY_COUNT:   r_key_count   <= i_cfg_data[KEY_COUNT_W-1:0];
                    CFG_LOOP_FRAMES: r_loop_frames <= i_cfg_data[FRAME_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_result     <= n_result;
        r_xneg       <= n_xneg;
        r_period     <= n_period;
        r_wrap       <= n_wrap;
        r_idx        <= n_idx;
        r_prev_frame <= n_prev_frame;
        r_prev_value <= n_prev_value;
        r_v0         <= n_v0;
        r_diff       <= n_diff;
        r_dw         <= n_dw;
        r_den        <= n_den;
        r_neg        <= n_neg;
    end

    // Keyframe table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[AW'(i_item.key_index)] <= {i_item.key_frame, i_item.key_value};
        end
        r_rdata <= mem[rd_addr];
    end

    kti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (div_cmd),
        .o_rsp   (div_rsp)
    );

    assign o_busy      = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_result    = r_result;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

@@ hdl/kti_checker.sv @@
`default_nettype none

`include "keyframe_track_interpolator_assert.svh"

module kti_checker
    import kti_pkg::*;
(
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    i_start,
    input wire t_item   i_item,
    input wire logic    o_busy,
    input wire logic    o_done,
    input wire t_result o_result
);

    logic eval_beat;
    logic write_beat;

    assign eval_beat  = i_start && !o_busy && (i_item.opcode == OP_EVAL);
    assign write_beat = i_start && !o_busy && (i_item.opcode == OP_WRITE);

    // An evaluation holds the block busy, with no result strobe, on the next cycle
    `KTI_ASSERT_NEXT(a_eval_busy, eval_beat, o_busy && !o_done)
    // A write answers on the next cycle with an all-zero result
    `KTI_ASSERT_NEXT(a_write_result, write_beat, o_done && (o_result == '0))
    // The strobe only shows once the sequencer is back at rest
    `KTI_ASSERT_SAME(a_done_idle, o_done, !o_busy)
    // No match means a zero value
    `KTI_ASSERT_SAME(a_nomatch_zero, o_done && !o_result.matched, o_result.track_value == '0)

endmodule

bind keyframe_track_interpolator kti_checker u_kti_checker (.*);

`default_nettype wire

@@ bench/tb_keyframe_track_interpolator.sv @@
`timescale 1ns / 1ps

module tb_keyframe_track_interpolator;
    import kti_pkg::*;

    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int RANDOM_ITEMS  = 1650;
    localparam int SETTLE_CYCLES = 120;

    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  cfg_index;
        logic [CFG_DATA_W-1:0] cfg_data;
        t_item                 item;
        logic                  pinned;
        t_result               result;
    } t_step;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_start;
    t_item                 i_item;
    logic                  o_busy;
    logic                  o_done;
    t_result               o_result;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Shadow of the keyframe table and the two registers
    logic [FRAME_W-1:0]        frame_tab [MAX_KEYS_DEF];
    logic signed [VALUE_W-1:0] value_tab [MAX_KEYS_DEF];
    logic [KEY_COUNT_W-1:0]    key_count_reg;
    logic [FRAME_W-1:0]        loop_frames_reg;

    t_result owed_results [$];
    t_step   plan [$];
    int      bad_count   = 0;
    int      cycle_count = 0;
    int      items_sent  = 0;
    int      gap_pct     = 0;
    logic    pin_valid   = 1'b0;
    t_result pin_result  = '0;

    keyframe_track_interpolator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_item      (i_item),
        .o_busy      (o_busy),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_result interpolate_step(t_item it);
        t_result res;
        int      total;
        int      period;
        int      rem;
        int      keys;
        longint  w, f0, f1, v0, v1, acc;
        res = '0;
        if (it.opcode == OP_WRITE) begin
            frame_tab[it.key_index] = it.key_frame;
            value_tab[it.key_index] = it.key_value;
        end else begin
            total  = $signed(it.play_frame) + $signed(it.frame_shift);
            period = (loop_frames_reg < 16'd2) ? 1 : int'(loop_frames_reg) - 1;
            // truncating remainder, pulled back into range when negative
            rem = (total - 1) % period;
            if (rem < 0) begin
                rem += period;
            end
            w = rem + 1;
            res.wrapped_frame = w[FRAME_W-1:0];
            keys = (key_count_reg > MAX_KEYS_DEF) ? MAX_KEYS_DEF : int'(key_count_reg);
            for (int i = 0; i + 1 < keys && !res.matched; i++) begin
                f0 = frame_tab[i];
                f1 = frame_tab[i + 1];
                if (w >= f0 && w <= f1) begin
                    v0 = value_tab[i];
                    v1 = value_tab[i + 1];
                    acc = (f1 != f0) ? v0 + ((v1 - v0) * (w - f0)) / (f1 - f0) : v0;
                    res.track_value = acc[VALUE_W-1:0];
                    res.matched     = 1'b1;
                end
            end
        end
        return res;
    endfunction

    task automatic note_bad(string what, t_result want, t_result got);
        bad_count++;
        if (bad_count <= 10) begin
            $display("%0t %s: want value %h frame %0d hit %b, got value %h frame %0d hit %b",
                     $realtime, what, want.track_value, want.wrapped_frame, want.matched,
                     got.track_value, got.wrapped_frame, got.matched);
        end
    endtask

    // Retire results first, then log the beat accepted at this edge
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            key_count_reg   = '0;
            loop_frames_reg = 16'd2;
        end else begin
            if (o_done) begin
                if (owed_results.size() == 0) begin
                    note_bad("result with nothing owed", '0, o_result);
                end else begin
                    want = owed_results.pop_front();
                    if (o_result.track_value !== want.track_value ||
                        o_result.wrapped_frame !== want.wrapped_frame ||
                        o_result.matched !== want.matched) begin
                        note_bad("mismatch", want, o_result);
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_KEY_COUNT:   key_count_reg   = i_cfg_data[KEY_COUNT_W-1:0];
                    CFG_LOOP_FRAMES: loop_frames_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !o_busy) begin
                want = interpolate_step(i_item);
                if (pin_valid) begin
                    want = pin_result;
                end
                owed_results.push_back(want);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_item(t_item it, logic pinned, t_result res);
        @(negedge i_clk);
        i_start    <= 1'b1;
        i_item     <= it;
        pin_valid  = pinned;
        pin_result = res;
        do @(posedge i_clk); while (o_busy);
        items_sent++;
    endtask

    // Hold start low until every owed result is back
    task automatic drain();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (owed_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic pace();
        int n;
        if ($urandom_range(0, 99) < gap_pct) begin
            n = $urandom_range(1, 8);
            @(negedge i_clk);
            i_start <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    function automatic t_item rand_item(logic op);
        t_item it;
        int    a, b, c;
        a = $urandom;
        b = $urandom;
        c = $urandom;
        it.opcode      = op;
        it.key_index   = a[5:0];
        it.key_frame   = a[21:6];
        it.key_value   = b;
        it.play_frame  = c[15:0];
        it.frame_shift = c[31:16];
        return it;
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        int v;
        case ($urandom_range(0, 11))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7FFF_FFFF;
            2:       v = 0;
            3:       v = -1;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic t_step reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        t_step s;
        s           = '0;
        s.is_cfg    = 1'b1;
        s.cfg_index = idx;
        s.cfg_data  = val;
        return s;
    endfunction

    // A write always answers with all fields zero
    function automatic t_step key_row(int slot, int frame, int value);
        t_step s;
        s                = '0;
        s.item.opcode    = OP_WRITE;
        s.item.key_index = slot[5:0];
        s.item.key_frame = frame[15:0];
        s.item.key_value = value;
        s.pinned         = 1'b1;
        return s;
    endfunction

    function automatic t_step eval_row(int play, int shift);
        t_step s;
        s                  = '0;
        s.item.opcode      = OP_EVAL;
        s.item.play_frame  = play[15:0];
        s.item.frame_shift = shift[15:0];
        return s;
    endfunction

    function automatic t_step eval_pin(int play, int shift, int value, int frame, logic hit);
        t_step s;
        s                      = eval_row(play, shift);
        s.pinned               = 1'b1;
        s.result.track_value   = value;
        s.result.wrapped_frame = frame[15:0];
        s.result.matched       = hit;
        return s;
    endfunction

    task automatic play_scene();
        int                    period, keys, span, step_max, frame, pick, n_evals;
        logic                  shuffled;
        logic [CFG_DATA_W-1:0] lf;
        logic [CFG_DATA_W-1:0] kc;
        t_item                 it;
        pick = $urandom;
        case ($urandom_range(0, 9))
            0:       lf = {15'd0, pick[0]};
            1:       lf = 16'hFFFF;
            2:       lf = pick[15:0];
            default: begin
                pick = $urandom_range(2, 400);
                lf   = pick[15:0];
            end
        endcase
        pick = $urandom;
        case ($urandom_range(0, 9))
            0:       kc = {15'd0, pick[0]};
            1:       kc = {9'd0, 1'b1, pick[5:0]};
            2:       kc = {9'd0, pick[6:0]};
            default: begin
                pick = $urandom_range(2, 64);
                kc   = pick[15:0];
            end
        endcase
        // junk in the upper data bits must not reach the count
        if ($urandom_range(0, 3) == 0) begin
            pick = $urandom;
            kc[15:7] = pick[8:0];
        end
        drain();
        write_reg(CFG_LOOP_FRAMES, lf);
        write_reg(CFG_KEY_COUNT, kc);

        period   = (lf < 16'd2) ? 1 : int'(lf) - 1;
        keys     = (kc[6:0] > 7'd64) ? 64 : int'(kc[6:0]);
        span     = period + 1;
        step_max = (2 * span) / ((keys > 0) ? keys : 1) + 1;
        frame    = $urandom_range(0, 2);
        shuffled = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < keys; k++) begin
            it           = rand_item(OP_WRITE);
            it.key_index = k[5:0];
            it.key_value = pick_value();
            if (shuffled) begin
                pick         = $urandom_range(0, span);
                it.key_frame = pick[15:0];
            end else begin
                it.key_frame = (frame > 65535) ? 16'hFFFF : frame[15:0];
                if ($urandom_range(0, 9) != 0) begin
                    frame += $urandom_range(0, step_max);
                end
            end
            pace();
            send_item(it, 1'b0, '0);
        end

        n_evals = $urandom_range(15, 40);
        repeat (n_evals) begin
            if ($urandom_range(0, 19) == 0) begin
                it           = rand_item(OP_WRITE);
                it.key_value = pick_value();
            end else begin
                it = rand_item(OP_EVAL);
                if ($urandom_range(0, 4) != 0) begin
                    pick           = $urandom_range(0, (span > 32767) ? 32767 : span);
                    it.play_frame  = pick[15:0];
                    pick           = $urandom_range(0, 40) - 20;
                    it.frame_shift = pick[15:0];
                end
            end
            pace();
            send_item(it, 1'b0, '0);
        end
    endtask

    initial begin
        int    base;
        t_item it;
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;

        // After reset: short loop, no keys
        plan.push_back(eval_pin(0, 0, 0, 1, 1'b0));
        plan.push_back(eval_pin(32767, 32767, 0, 1, 1'b0));
        plan.push_back(eval_pin(-32768, -32768, 0, 1, 1'b0));
        plan.push_back(key_row(0, 10, 32'h8000_0000));
        plan.push_back(key_row(1, 10, 32'h0001_0000));
        plan.push_back(key_row(2, 110, 32'h7FFF_FFFF));
        plan.push_back(key_row(3, 65535, 32'hFFFF_0000));
        plan.push_back(key_row(63, 65535, 32'hFFFF_FFFF));
        plan.push_back(reg_row(CFG_LOOP_FRAMES, 16'hFFFF));
        plan.push_back(reg_row(CFG_KEY_COUNT, 16'd4));
        // first segment has equal frames: take its start value
        plan.push_back(eval_pin(10, 0, 32'h8000_0000, 10, 1'b1));
        plan.push_back(eval_row(30, 30));
        plan.push_back(eval_pin(5, 0, 0, 5, 1'b0));
        plan.push_back(eval_pin(110, 0, 32'h7FFF_FFFF, 110, 1'b1));
        plan.push_back(eval_row(0, 0));
        plan.push_back(eval_row(32767, 32767));
        plan.push_back(eval_row(-32768, -32768));
        plan.push_back(reg_row(CFG_KEY_COUNT, 16'd1));
        plan.push_back(eval_pin(60, 0, 0, 60, 1'b0));
        plan.push_back(reg_row(CFG_KEY_COUNT, 16'd4));
        plan.push_back(reg_row(CFG_LOOP_FRAMES, 16'd0));
        plan.push_back(eval_pin(1234, -7, 0, 1, 1'b0));
        plan.push_back(reg_row(CFG_LOOP_FRAMES, 16'd1));
        plan.push_back(eval_pin(-32768, 32767, 0, 1, 1'b0));
        plan.push_back(reg_row(CFG_LOOP_FRAMES, 16'd101));
        plan.push_back(eval_row(-1, 0));
        plan.push_back(eval_row(0, 0));

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[r]) begin
            if (plan[r].is_cfg) begin
                drain();
                write_reg(plan[r].cfg_index, plan[r].cfg_data);
            end else begin
                send_item(plan[r].item, plan[r].pinned, plan[r].result);
            end
        end

        // Fill every slot so that any key count reads written entries only
        base    = items_sent;
        gap_pct = 20;
        for (int k = 0; k < MAX_KEYS_DEF; k++) begin
            it           = rand_item(OP_WRITE);
            it.key_index = k[5:0];
            it.key_value = pick_value();
            pace();
            send_item(it, 1'b0, '0);
        end

        while (items_sent - base < RANDOM_ITEMS) begin
            if (items_sent - base < RANDOM_ITEMS / 3) begin
                gap_pct = 20;
            end else if (items_sent - base < 2 * RANDOM_ITEMS / 3) begin
                gap_pct = 63;
            end else begin
                gap_pct = 0;
            end
            play_scene();
        end

        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (bad_count == 0 && owed_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/kti_pkg.sv
hdl/kti_div.sv
hdl/keyframe_track_interpolator.sv
hdl/kti_checker.sv
bench/tb_keyframe_track_interpolator.sv
